// File: rtl/dbpa_pkg.sv
// types, constants and helper functions for the display buffer pool allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dbpa_pkg;

    localparam int MAX_BUFFERS = 8;
    localparam logic [3:0] MAX_SLOT   = 4'(MAX_BUFFERS);
    localparam logic [3:0] RESET_POOL = 4'd2;
    localparam logic signed [15:0] NO_ID = -16'sd1;

    typedef logic [3:0] t_slot;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_ACQUIRE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_MARK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        USE_FREE = 2'd0,
        USE_CUR  = 2'd1,
        USE_PREP = 2'd2
    } t_use;

    typedef enum logic [2:0] {
        RULE_ID_MATCH = 3'd0,
        RULE_BLANK    = 3'd1,
        RULE_ANY_FREE = 3'd2,
        RULE_FORCED   = 3'd3,
        RULE_NONE     = 3'd4
    } t_rule;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_GRANT,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic signed [15:0] buffer_id;
        logic               high_priority;
        t_slot              slot;
    } t_dbpa_in;

    typedef struct packed {
        logic  ok;
        t_slot granted_slot;
        t_rule rule_used;
    } t_dbpa_out;

    typedef struct packed {
        logic signed [15:0] id;
        t_use               use_state;
        logic               filled;
    } t_entry;

    // decision of the scan unit, valid once the scan has passed the last slot
    typedef struct packed {
        logic  ok;
        t_slot slot;
        t_rule rule;
    } t_dbpa_dec;

    // contents of one slot right after a table rebuild with n common buffers
    function automatic t_entry init_entry(input t_slot idx, input t_slot n);
        t_entry e;
        e.id        = (idx == n) ? 16'sd0 : NO_ID;
        e.use_state = (idx == n && n != 4'd0) ? USE_CUR : USE_FREE;
        e.filled    = 1'b0;
        return e;
    endfunction

    function automatic t_slot sat_pool(input logic [3:0] p);
        return (p > MAX_SLOT) ? MAX_SLOT : p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dbpa_table.sv
// slot table: one entry per common buffer plus the device buffer
// one read port, one write port; depends on dbpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbpa_table
    import dbpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_slot  i_rd_idx,
    output t_entry      o_rd_entry,
    input  wire logic   i_wr_en,
    input  wire t_slot  i_wr_idx,
    input  wire t_entry i_wr_entry
);

    t_entry r_entry [MAX_BUFFERS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= MAX_BUFFERS; i++) begin
                r_entry[i] <= init_entry(4'(i), RESET_POOL);
            end
        end else if (i_wr_en && i_wr_idx <= MAX_SLOT) begin
            r_entry[i_wr_idx] <= i_wr_entry;
        end
    end

    always_comb begin
        if (i_rd_idx <= MAX_SLOT) begin
            o_rd_entry = r_entry[i_rd_idx];
        end else begin
            o_rd_entry = init_entry(i_rd_idx, RESET_POOL);
        end
    end

endmodule

`default_nettype wire

// File: rtl/dbpa_scan.sv
// shared compare unit: checks one slot a cycle while i_en is high against all
// three search rules and keeps the first hit of each; depends on dbpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbpa_scan
    import dbpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_clear,
    input  wire logic               i_en,
    input  wire t_slot              i_idx,
    input  wire t_entry             i_entry,
    input  wire logic signed [15:0] i_req_id,
    input  wire logic               i_high,
    output t_dbpa_dec               o_dec
);

    logic  r_hit_id, r_hit_blank, r_hit_free;
    t_slot r_slot_id, r_slot_blank, r_slot_free;
    logic  w_free;

    assign w_free = (i_entry.use_state == USE_FREE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_id    <= 1'b0;
            r_hit_blank <= 1'b0;
            r_hit_free  <= 1'b0;
        end else if (i_clear) begin
            r_hit_id    <= 1'b0;
            r_hit_blank <= 1'b0;
            r_hit_free  <= 1'b0;
        end else if (i_en) begin
            // only the first hit of each rule counts
            if (!r_hit_id && w_free && i_entry.id == i_req_id) begin
                r_hit_id <= 1'b1;
            end
            if (!r_hit_blank && w_free && !i_entry.filled) begin
                r_hit_blank <= 1'b1;
            end
            if (!r_hit_free && w_free) begin
                r_hit_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_hit_id) begin
                r_slot_id <= i_idx;
            end
            if (!r_hit_blank) begin
                r_slot_blank <= i_idx;
            end
            if (!r_hit_free) begin
                r_slot_free <= i_idx;
            end
        end
    end

    always_comb begin
        if (r_hit_id) begin
            o_dec = '{ok: 1'b1, slot: r_slot_id, rule: RULE_ID_MATCH};
        end else if (r_hit_blank) begin
            o_dec = '{ok: 1'b1, slot: r_slot_blank, rule: RULE_BLANK};
        end else if (r_hit_free) begin
            o_dec = '{ok: 1'b1, slot: r_slot_free, rule: RULE_ANY_FREE};
        end else if (i_high) begin
            o_dec = '{ok: 1'b1, slot: 4'd0, rule: RULE_FORCED};
        end else begin
            o_dec = '{ok: 1'b0, slot: 4'd0, rule: RULE_NONE};
        end
    end

endmodule

`default_nettype wire

// File: rtl/display_buffer_pool_allocator_unit.sv
// top level of the display buffer pool allocator: sequencer, config register
// depends on dbpa_pkg, dbpa_table, dbpa_scan
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: a beat on i_item is taken at a rising edge with start
//   high and busy low. busy stays high until the command has finished.
//   Result channel: one beat per command on o_result, marked by o_strobe for
//   exactly one cycle; the receiver must take it, there is no back-pressure.
//   Config: i_cfg_we writes pool_count from i_cfg_wdata; it takes effect at
//   the next init command. Write it only while busy is low.
// Command sequences
//   init:            every table entry rewritten, one table entry a cycle
//   acquire:         one slot a cycle through the
//                    shared compare unit, then a grant state
//   release, mark:   one read-modify-write of the slot
//   A new command may be started in the cycle the strobe is shown; no new
//   command is taken while one is still in flight.
// Reset
//   synchronous, active low: pool size 2, table as after an init with two
//   common buffers, no result pending.
module display_buffer_pool_allocator_unit
    import dbpa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_dbpa_in  i_item,
    input  wire logic      i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    output logic           o_strobe,
    output t_dbpa_out      o_result
);

    t_state    r_state, n_state;
    t_slot     r_idx, n_idx;
    t_slot     r_last, n_last;
    logic [3:0] r_pool;
    t_dbpa_in  r_req, n_req;
    t_dbpa_out r_out, n_out;
    logic      r_strobe, n_strobe;

    t_slot     w_rd_idx;
    t_entry    w_rd_entry;
    logic      w_wr_en;
    t_slot     w_wr_idx;
    t_entry    w_wr_entry;
    logic      w_scan_clear, w_scan_en;
    t_dbpa_dec w_dec;

    dbpa_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (w_rd_idx),
        .o_rd_entry (w_rd_entry),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (w_wr_idx),
        .i_wr_entry (w_wr_entry)
    );

    dbpa_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_scan_clear),
        .i_en     (w_scan_en),
        .i_idx    (r_idx),
        .i_entry  (w_rd_entry),
        .i_req_id (r_req.buffer_id),
        .i_high   (r_req.high_priority),
        .o_dec    (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_last   <= RESET_POOL;
            r_pool   <= RESET_POOL;
            r_strobe <= 1'b0;
            r_idx    <= 4'd0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_strobe <= n_strobe;
            r_idx    <= n_idx;
            if (i_cfg_we) begin
                r_pool <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_last       = r_last;
        n_req        = r_req;
        n_out        = r_out;
        n_strobe     = 1'b0;
        w_rd_idx     = r_idx;
        w_wr_en      = 1'b0;
        w_wr_idx     = r_idx;
        w_wr_entry   = w_rd_entry;
        w_scan_clear = 1'b0;
        w_scan_en    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req        = i_item;
                    n_idx        = 4'd0;
                    w_scan_clear = 1'b1;
                    case (i_item.command)
                        CMD_INIT: begin
                            n_last  = sat_pool(r_pool);
                            n_state = ST_INIT;
                        end
                        CMD_ACQUIRE: n_state = ST_SCAN;
                        default:     n_state = ST_UPDATE;
                    endcase
                end
            end
            ST_INIT: begin
                w_wr_en    = 1'b1;
                w_wr_entry = init_entry(r_idx, r_last);
                if (r_idx == MAX_SLOT) begin
                    n_out    = '{ok: 1'b1, granted_slot: 4'd0, rule_used: RULE_NONE};
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_idx = 4'(r_idx + 4'd1);
                end
            end
            ST_SCAN: begin
                w_scan_en = 1'b1;
                if (r_idx == r_last) begin
                    n_state = ST_GRANT;
                end else begin
                    n_idx = 4'(r_idx + 4'd1);
                end
            end
            ST_GRANT: begin
                w_rd_idx = w_dec.slot;
                w_wr_idx = w_dec.slot;
                w_wr_en  = w_dec.ok;
                w_wr_entry.id        = r_req.buffer_id;
                w_wr_entry.use_state = r_req.high_priority ? USE_CUR : USE_PREP;
                // any-free and forced grants hand over a blank buffer
                if (w_dec.rule == RULE_ANY_FREE || w_dec.rule == RULE_FORCED) begin
                    w_wr_entry.filled = 1'b0;
                end
                n_out    = '{ok: w_dec.ok, granted_slot: w_dec.slot,
                             rule_used: w_dec.rule};
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_UPDATE: begin
                w_rd_idx = r_req.slot;
                w_wr_idx = r_req.slot;
                w_wr_en  = (r_req.slot <= r_last);
                if (r_req.command == CMD_RELEASE) begin
                    w_wr_entry.use_state = USE_FREE;
                    if (w_rd_entry.id == NO_ID) begin
                        w_wr_entry.filled = 1'b0;
                    end
                end else begin
                    w_wr_entry.filled = 1'b1;
                end
                n_out    = '{ok: (r_req.slot <= r_last), granted_slot: 4'd0,
                             rule_used: RULE_NONE};
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: rtl/dbpa_checker.sv
// port-level checks for the display buffer pool allocator, bound to the top
// depends on dbpa_pkg and display_buffer_pool_allocator_unit
`timescale 1ns / 1ps
`default_nettype none

module dbpa_checker
    import dbpa_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_strobe,
    input wire t_dbpa_out o_result
);

    // a result beat is only ever shown once the unit is no longer busy
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while still busy");

    // an accepted command first makes the unit busy, with no result beat yet
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("command accepted without going busy");

    // finishing a command always produces a beat
    a_fell_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result beat");

    // a failed command never names a slot or a rule
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.ok) |->
            (o_result.granted_slot == 4'd0 && o_result.rule_used == RULE_NONE))
        else $error("failed command reports a slot or rule");

endmodule

bind display_buffer_pool_allocator_unit dbpa_checker u_dbpa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
